/* hw/rtl/mvfb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvfb_pkg
// Shared types and constants of the motion vector flow blur block.
// ----------------------------------------------------------------------------
package mvfb_pkg;

  localparam int SAMPLE_BITS_DEF     = 8;
  localparam int STORE_ADDR_BITS_DEF = 20;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 20;
  localparam int VEC_BITS       = 13;
  localparam int POS_BITS       = 12;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] REG_BLUR_AMOUNT    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_PRECISION = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOG_PEL        = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_STRIDE     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN         = 3'd4;

  // Configuration register set.
  typedef struct packed {
    logic [8:0]  blur_amount;
    logic [8:0]  step_precision;
    logic [1:0]  log_pel;
    logic [15:0] ref_row_stride;
    logic [19:0] origin_address;
  } mvfb_cfg_t;

  // Input request fields.
  typedef struct packed {
    logic        func;
    logic [19:0] load_address;
    logic [15:0] load_sample;
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
    logic signed [12:0] fwd_vx;
    logic signed [12:0] fwd_vy;
    logic signed [12:0] bwd_vx;
    logic signed [12:0] bwd_vy;
  } mvfb_req_t;

endpackage : mvfb_pkg
`default_nettype wire

/* hw/rtl/mvfb_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvfb_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mvfb_divider #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quotient
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    trial;

  assign trial    = {rem, quo[W-1]} - {1'b0, dvs};
  assign quotient = quo;

  // Shift one dividend bit in per cycle and subtract where it fits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], quo[W-1]};
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

endmodule : mvfb_divider
`default_nettype wire

/* hw/rtl/mvfb_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvfb_store
// Reference sample store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mvfb_store #(
  parameter int SAMPLE_BITS     = 8,
  parameter int STORE_ADDR_BITS = 20
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [STORE_ADDR_BITS-1:0] wr_addr,
  input  wire logic [SAMPLE_BITS-1:0]     wr_data,
  input  wire logic                       rd_en,
  input  wire logic [STORE_ADDR_BITS-1:0] rd_addr,
  output logic      [SAMPLE_BITS-1:0]     rd_data
);
  logic [SAMPLE_BITS-1:0] mem [2**STORE_ADDR_BITS];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port: rd_data holds the sample in the cycle after rd_en.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : mvfb_store
`default_nettype wire

/* hw/rtl/mvfb_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvfb_engine
// Sequencer that writes load samples, computes path steps, gathers samples and averages them.
// ----------------------------------------------------------------------------
module mvfb_engine #(
  parameter int SAMPLE_BITS     = 8,
  parameter int STORE_ADDR_BITS = 20
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire mvfb_pkg::mvfb_cfg_t        cfg,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire mvfb_pkg::mvfb_req_t        in_req,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [15:0]                     out_sample,
  output logic                            out_clamped,
  output logic                            st_wr_en,
  output logic [STORE_ADDR_BITS-1:0]      st_wr_addr,
  output logic [SAMPLE_BITS-1:0]          st_wr_data,
  output logic                            st_rd_en,
  output logic [STORE_ADDR_BITS-1:0]      st_rd_addr,
  input  wire logic [SAMPLE_BITS-1:0]     st_rd_data
);
  import mvfb_pkg::*;

  localparam int DW  = 32;
  // Signed address width: base is below 2^45.
  localparam int AW  = 48;
  localparam int SW  = 24;
  localparam int CNW = 22;
  localparam int SUMW = SAMPLE_BITS + CNW + 1;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_BASE   = 11'b00000000010,
    S_CENTRE = 11'b00000000100,
    S_DIR    = 11'b00000001000,
    S_CDIV   = 11'b00000010000,
    S_XDIV   = 11'b00000100000,
    S_YDIV   = 11'b00001000000,
    S_GATHER = 11'b00010000000,
    S_ADIV   = 11'b00100000000,
    S_AWAIT  = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_t;

  state_t state, state_next;

  mvfb_req_t req;
  logic signed [AW-1:0] base;
  logic                 dir;
  logic signed [SW-1:0] sx, sy, stx, sty, px, py;
  logic [CNW-1:0]       cnt, idx;
  logic [CNW:0]         total;
  logic [SUMW-1:0]      sum;
  logic                 clamped;
  logic                 rd_pend;
  logic [DW-1:0]        ax_r, ay_r;

  logic                 div_start;
  logic [DW-1:0]        div_a, div_b, div_q;
  logic                 div_done;

  mvfb_divider #(.W(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quotient(div_q)
  );

  // Scaled vector of the current direction.
  logic signed [12:0] vx_sel, vy_sel;
  logic signed [SW-1:0] mx, my;
  assign vx_sel = dir ? req.bwd_vx : req.fwd_vx;
  assign vy_sel = dir ? req.bwd_vy : req.fwd_vy;
  assign mx = SW'(vx_sel) * $signed({1'b0, cfg.blur_amount});
  assign my = SW'(vy_sel) * $signed({1'b0, cfg.blur_amount});

  // Centre position terms: the row product needs up to 31 bits.
  logic [14:0] row_sh, col_sh;
  logic [30:0] row_prod;
  assign row_sh   = {3'd0, req.pixel_row} << cfg.log_pel;
  assign col_sh   = {3'd0, req.pixel_col} << cfg.log_pel;
  assign row_prod = 31'(row_sh) * 31'(cfg.ref_row_stride);

  // Path address: base + floor(py/256)*stride + floor(px/256).
  logic signed [SW-9:0] fy, fx;
  logic signed [AW-1:0] rowoff, path_addr, rd_full;
  logic                 out_lo, out_hi;
  assign fy = py[SW-1:8];
  assign fx = px[SW-1:8];
  assign rowoff = AW'(fy) * $signed({1'b0, cfg.ref_row_stride});

  always_ff @(posedge clk) begin
    path_addr <= base + rowoff + AW'(fx);
  end

  logic                 addr_stage;
  logic signed [AW-1:0] sel_addr;
  assign sel_addr = (state == S_CENTRE) ? base : path_addr;
  assign out_lo = sel_addr < 0;
  assign out_hi = sel_addr > $signed(AW'((64'd1 << STORE_ADDR_BITS) - 1));
  assign rd_full = sel_addr;
  assign st_rd_addr = out_lo ? '0 : out_hi ? '1 : rd_full[STORE_ADDR_BITS-1:0];

  assign in_ready   = (state == S_IDLE);
  assign st_wr_en   = in_valid && in_ready && !in_req.func;
  assign st_wr_addr = STORE_ADDR_BITS'(in_req.load_address);
  assign st_wr_data = in_req.load_sample[SAMPLE_BITS-1:0];

  logic [DW-1:0] prec;
  assign prec = (cfg.step_precision == '0) ? DW'(1) : DW'(cfg.step_precision);

  // Next-state logic.
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_a      = ax_r;
    div_b      = prec;
    st_rd_en   = 1'b0;
    unique case (state)
      S_IDLE:   if (in_valid && in_req.func) state_next = S_BASE;
      S_BASE:   state_next = S_CENTRE;
      S_CENTRE: begin
        st_rd_en   = 1'b1;
        state_next = S_DIR;
      end
      S_DIR: begin
        div_start  = 1'b1;
        div_a      = (mx < 0 ? DW'(-mx) : DW'(mx)) > (my < 0 ? DW'(-my) : DW'(my)) ?
                     (mx < 0 ? DW'(-mx) : DW'(mx)) : (my < 0 ? DW'(-my) : DW'(my));
        state_next = S_CDIV;
      end
      S_CDIV: if (div_done) begin
        if (div_q[DW-1:8] == '0) begin
          state_next = dir ? S_ADIV : S_DIR;
        end else begin
          div_start  = 1'b1;
          div_a      = ax_r;
          div_b      = DW'(div_q[DW-1:8]);
          state_next = S_XDIV;
        end
      end
      S_XDIV: if (div_done) begin
        div_start  = 1'b1;
        div_a      = ay_r;
        div_b      = DW'(cnt);
        state_next = S_YDIV;
      end
      S_YDIV: if (div_done) state_next = S_GATHER;
      S_GATHER: begin
        st_rd_en = addr_stage;
        if (addr_stage && idx == cnt) state_next = dir ? S_ADIV : S_DIR;
      end
      S_ADIV: begin
        div_start  = !rd_pend;
        div_a      = DW'(sum);
        div_b      = DW'(total);
        if (!rd_pend) state_next = S_AWAIT;
      end
      S_AWAIT:  if (div_done) state_next = S_OUT;
      S_OUT:    if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= st_rd_en;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rd_pend) sum <= sum + SUMW'(st_rd_data);
    unique case (state)
      S_IDLE: if (in_valid && in_req.func) begin
        req     <= in_req;
        dir     <= 1'b0;
        clamped <= 1'b0;
        sum     <= '0;
        total   <= (CNW+1)'(1);
      end
      S_BASE: begin
        base <= $signed({28'd0, cfg.origin_address})
              + $signed({17'd0, row_prod})
              + $signed({33'd0, col_sh});
      end
      S_CENTRE: if (out_lo || out_hi) clamped <= 1'b1;
      S_DIR: begin
        sx   <= mx;
        sy   <= my;
        ax_r <= mx < 0 ? DW'(-mx) : DW'(mx);
        ay_r <= my < 0 ? DW'(-my) : DW'(my);
      end
      S_CDIV: if (div_done) begin
        cnt <= CNW'(div_q[DW-1:8]);
        if (div_q[DW-1:8] == '0) dir <= 1'b1;
      end
      S_XDIV: if (div_done) stx <= sx < 0 ? -SW'(div_q) : SW'(div_q);
      S_YDIV: if (div_done) begin
        sty        <= sy < 0 ? -SW'(div_q) : SW'(div_q);
        px         <= stx;
        py         <= sy < 0 ? -SW'(div_q) : SW'(div_q);
        idx        <= CNW'(1);
        addr_stage <= 1'b0;
      end
      S_GATHER: begin
        addr_stage <= !addr_stage;
        if (addr_stage) begin
          if (out_lo || out_hi) clamped <= 1'b1;
          total <= total + 1'b1;
          px    <= px + stx;
          py    <= py + sty;
          idx   <= idx + 1'b1;
          if (idx == cnt) dir <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_sample  = div_q[15:0];
  assign out_clamped = clamped;

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_rd_latency: assert property (@(posedge clk) disable iff (rst)
    st_rd_en |=> rd_pend) else $error("read pending lost");
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    st_wr_en |-> state == S_IDLE) else $error("store written while busy");
`endif

endmodule : mvfb_engine
`default_nettype wire

/* hw/rtl/motion_vector_flow_blur.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// motion_vector_flow_blur
// Motion compensated blur over a reference sample store.
// ----------------------------------------------------------------------------
// A load request writes one sample into the store. A blur request runs up
// to seven divisions, one after another, on one shared bit-serial divider:
// every direction finds its step count, and for a non-zero count works out
// its step sizes, then each path sample needs an address step and a store
// read; the final division averages the samples, and the result is held
// until the output takes it. Requests are handled one at a time, and
// configuration is taken only while idle.
module motion_vector_flow_blur #(
  parameter int SAMPLE_BITS     = mvfb_pkg::SAMPLE_BITS_DEF,
  parameter int STORE_ADDR_BITS = mvfb_pkg::STORE_ADDR_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [19:0]  cfg_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // load_address, load_sample, pixel_col, pixel_row, fwd_vx, fwd_vy,
  // bwd_vx, bwd_vy (lowest bits first), 112 bits
  input  wire logic [111:0] s_axis_tdata,
  // func
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // blurred_sample
  output logic [15:0]       m_axis_tdata,
  // address_clamped
  output logic              m_axis_tuser
);
  import mvfb_pkg::*;

  mvfb_cfg_t cfg;
  mvfb_req_t req;

  logic                       st_wr_en, st_rd_en;
  logic [STORE_ADDR_BITS-1:0] st_wr_addr, st_rd_addr;
  logic [SAMPLE_BITS-1:0]     st_wr_data, st_rd_data;
  logic [15:0]                out_sample;
  logic                       out_clamped;

  // Registers change only while no request is in flight.
  assign cfg_ready = s_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blur_amount    <= 9'd128;
      cfg.step_precision <= 9'd1;
      cfg.log_pel        <= 2'd0;
      cfg.ref_row_stride <= 16'd1024;
      cfg.origin_address <= 20'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BLUR_AMOUNT:    cfg.blur_amount    <= cfg_data[8:0];
        REG_STEP_PRECISION: cfg.step_precision <= cfg_data[8:0];
        REG_LOG_PEL:        cfg.log_pel        <= cfg_data[1:0];
        REG_ROW_STRIDE:     cfg.ref_row_stride <= cfg_data[15:0];
        REG_ORIGIN:         cfg.origin_address <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // Unpack the request.
  assign req.func         = s_axis_tuser;
  assign req.load_address = s_axis_tdata[19:0];
  assign req.load_sample  = s_axis_tdata[35:20];
  assign req.pixel_col    = s_axis_tdata[47:36];
  assign req.pixel_row    = s_axis_tdata[59:48];
  assign req.fwd_vx       = s_axis_tdata[72:60];
  assign req.fwd_vy       = s_axis_tdata[85:73];
  assign req.bwd_vx       = s_axis_tdata[98:86];
  assign req.bwd_vy       = s_axis_tdata[111:99];

  mvfb_engine #(.SAMPLE_BITS(SAMPLE_BITS), .STORE_ADDR_BITS(STORE_ADDR_BITS)) u_engine (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(req),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_sample(out_sample), .out_clamped(out_clamped),
    .st_wr_en(st_wr_en), .st_wr_addr(st_wr_addr), .st_wr_data(st_wr_data),
    .st_rd_en(st_rd_en), .st_rd_addr(st_rd_addr), .st_rd_data(st_rd_data)
  );

  mvfb_store #(.SAMPLE_BITS(SAMPLE_BITS), .STORE_ADDR_BITS(STORE_ADDR_BITS)) u_store (
    .clk(clk), .wr_en(st_wr_en), .wr_addr(st_wr_addr), .wr_data(st_wr_data),
    .rd_en(st_rd_en), .rd_addr(st_rd_addr), .rd_data(st_rd_data)
  );

  assign m_axis_tdata = out_sample;
  assign m_axis_tuser = out_clamped;

endmodule : motion_vector_flow_blur
`default_nettype wire
